// ===== design/ptb_pkg.sv =====
package ptb_pkg;

  // Bank geometry
  localparam int SLOTS = 16;
  localparam int INTERVAL_BITS = 20;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // Field widths
  localparam int OP_W = 2;
  localparam int FREQ_W = 21;
  localparam int IDX_W = 4;
  localparam int MASK_W = 16;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W = 2;

  // Largest reload interval
  localparam logic [63:0] IVAL_MAX = (64'd1 << INTERVAL_BITS) - 64'd1;

  // Divider step count and counter width
  localparam int DIV_STEPS = FREQ_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  // Operation codes
  localparam logic [OP_W-1:0] OP_TICK = 2'd0;
  localparam logic [OP_W-1:0] OP_REGISTER = 2'd1;
  localparam logic [OP_W-1:0] OP_UNREGISTER = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_ACTIVE = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TICK_RATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_FREQ = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FREQ = 2'd2;

  // Controller to datapath
  typedef struct packed {
    logic capture;    // latch the input transfer
    logic exec;       // op without division: update state, load result
    logic start_div;  // launch interval division
    logic commit;     // write new slot, load result
  } ptb_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_div;   // latched item is a register that will take a slot
    logic div_busy;
    logic out_free;   // result register can take a new value
  } ptb_stat_t;

endpackage

// ===== design/ptb_div.sv =====
module ptb_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [ptb_pkg::FREQ_W-1:0]    dividend,
  input  logic [ptb_pkg::FREQ_W-1:0]    divisor,
  output logic                          busy,
  output logic [ptb_pkg::FREQ_W-1:0]    quotient
);
  import ptb_pkg::*;

  logic [FREQ_W-1:0]    rem;
  logic [FREQ_W-1:0]    quo;
  logic [FREQ_W-1:0]    dvs;
  logic [DIV_CNT_W-1:0] cnt;
  logic [FREQ_W:0]      rem_sh;
  logic [FREQ_W:0]      diff;
  logic                 fits;

  // One restoring step: shift in next dividend bit, subtract if it fits
  always_comb begin
    rem_sh = {rem, quo[FREQ_W-1]};
    diff = rem_sh - {1'b0, dvs};
    fits = (rem_sh >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= DIV_CNT_W'(DIV_STEPS);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == DIV_CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Quotient bits shift into the dividend register
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= fits ? diff[FREQ_W-1:0] : rem_sh[FREQ_W-1:0];
      quo <= {quo[FREQ_W-2:0], fits};
    end
  end

  assign quotient = quo;

endmodule

// ===== design/ptb_datapath.sv =====
module ptb_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  ptb_pkg::ptb_cmd_t               cmd,
  output ptb_pkg::ptb_stat_t              stat,
  input  logic [ptb_pkg::OP_W-1:0]        operation,
  input  logic [ptb_pkg::FREQ_W-1:0]      frequency,
  input  logic [ptb_pkg::IDX_W-1:0]       slot_index,
  input  logic                            cfg_write,
  input  logic [ptb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ptb_pkg::FREQ_W-1:0]      cfg_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [ptb_pkg::MASK_W-1:0]      fired_mask,
  output logic [ptb_pkg::IDX_W-1:0]       assigned_slot,
  output logic [ptb_pkg::STATUS_W-1:0]    status
);
  import ptb_pkg::*;

  // Configuration
  logic [FREQ_W-1:0] tick_rate;
  logic [FREQ_W-1:0] min_frequency;
  logic [FREQ_W-1:0] max_frequency;

  // Latched item
  logic [OP_W-1:0]   op_q;
  logic [FREQ_W-1:0] freq_q;
  logic [IDX_W-1:0]  idx_q;

  // Slot state
  logic [SLOTS-1:0]             slot_active;
  logic [INTERVAL_BITS-1:0]     reload_interval [SLOTS];
  logic [INTERVAL_BITS-1:0]     remaining_ticks [SLOTS];

  logic                     freq_ok;
  logic                     bank_full;
  logic [SLOTS-1:0]         free_vec;
  logic [SLOTS-1:0]         pick;
  logic [SLOT_W-1:0]        pick_num;
  logic [SLOTS-1:0]         unreg_hit;
  logic [SLOTS-1:0]         fire;
  logic [MASK_W+SLOTS-1:0]  fire_wide;
  logic                     div_busy;
  logic [FREQ_W-1:0]        div_quo;
  logic [INTERVAL_BITS-1:0] new_ival;
  logic [STATUS_W-1:0]      exec_status;
  logic [MASK_W-1:0]        exec_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_rate <= FREQ_W'(100);
      min_frequency <= FREQ_W'(2);
      max_frequency <= FREQ_W'(1193180);
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_TICK_RATE: tick_rate <= cfg_data;
        CFG_MIN_FREQ:  min_frequency <= cfg_data;
        CFG_MAX_FREQ:  max_frequency <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q <= operation;
      freq_q <= frequency;
      idx_q <= slot_index;
    end
  end

  // Request checks and lowest free slot
  always_comb begin
    freq_ok = (freq_q != '0) && (freq_q >= min_frequency) && (freq_q <= max_frequency);
    free_vec = ~slot_active;
    bank_full = (slot_active == {SLOTS{1'b1}});
    pick = free_vec & (~free_vec + SLOTS'(1));
    pick_num = '0;
    for (int s = 0; s < SLOTS; s++) begin
      if (pick[s]) begin
        pick_num = pick_num | SLOT_W'(s);
      end
      unreg_hit[s] = (32'(idx_q) == s) && slot_active[s];
    end
  end

  // Per-slot expiry on a tick
  always_comb begin
    for (int s = 0; s < SLOTS; s++) begin
      fire[s] = slot_active[s] && (remaining_ticks[s] <= INTERVAL_BITS'(1));
    end
    fire_wide = (MASK_W + SLOTS)'(fire);
  end

  assign stat.need_div = (op_q == OP_REGISTER) && freq_ok && !bank_full;
  assign stat.div_busy = div_busy;
  assign stat.out_free = !out_valid || out_ready;

  ptb_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.start_div),
    .dividend (tick_rate),
    .divisor  (freq_q),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  // Quotient clamp: zero becomes one, overflow saturates
  always_comb begin
    if (div_quo == '0) begin
      new_ival = INTERVAL_BITS'(1);
    end else if (64'(div_quo) > IVAL_MAX) begin
      new_ival = INTERVAL_BITS'(IVAL_MAX);
    end else begin
      new_ival = INTERVAL_BITS'(div_quo);
    end
  end

  // Result of an op that needs no division
  always_comb begin
    exec_status = ST_OK;
    exec_mask = '0;
    case (op_q)
      OP_TICK:       exec_mask = fire_wide[MASK_W-1:0];
      OP_REGISTER:   exec_status = freq_ok ? ST_FULL : ST_RANGE;
      OP_UNREGISTER: exec_status = (unreg_hit != '0) ? ST_OK : ST_NOT_ACTIVE;
      default: ;
    endcase
  end

  // Slot activity
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_active <= '0;
    end else if (cmd.commit) begin
      slot_active <= slot_active | pick;
    end else if (cmd.exec && (op_q == OP_UNREGISTER)) begin
      slot_active <= slot_active & ~unreg_hit;
    end
  end

  // Interval stores: countdown on tick, load on commit
  always_ff @(posedge clk) begin
    for (int s = 0; s < SLOTS; s++) begin
      if (cmd.commit && pick[s]) begin
        reload_interval[s] <= new_ival;
        remaining_ticks[s] <= new_ival;
      end else if (cmd.exec && (op_q == OP_TICK) && slot_active[s]) begin
        remaining_ticks[s] <= fire[s] ? reload_interval[s]
                                      : remaining_ticks[s] - INTERVAL_BITS'(1);
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.exec || cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      fired_mask <= '0;
      assigned_slot <= IDX_W'((IDX_W + SLOT_W)'(pick_num));
      status <= ST_OK;
    end else if (cmd.exec) begin
      fired_mask <= exec_mask;
      assigned_slot <= '0;
      status <= exec_status;
    end
  end

endmodule

// ===== design/ptb_ctrl.sv =====
module ptb_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  ptb_pkg::ptb_stat_t stat,
  output ptb_pkg::ptb_cmd_t  cmd
);
  import ptb_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DIV
  } state_t;

  state_t state;

  assign in_ready = (state == S_IDLE);

  // Command decode
  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE: cmd.capture = in_valid;
      S_EXEC: begin
        cmd.start_div = stat.need_div;
        cmd.exec = !stat.need_div && stat.out_free;
      end
      S_DIV: cmd.commit = !stat.div_busy && stat.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) state <= S_EXEC;
        S_EXEC: begin
          if (stat.need_div) begin
            state <= S_DIV;
          end else if (stat.out_free) begin
            state <= S_IDLE;
          end
        end
        S_DIV: if (!stat.div_busy && stat.out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== design/periodic_timer_bank_core.sv =====
// Timing: tick, unregister and rejected register items load a result from S_EXEC once the
// result register is free; an accepted register loads it from S_DIV after the 21-step serial divider.
// Throughput: one item at a time; the next transfer can be taken the cycle after the result
// is loaded.
// Reset (rst, synchronous): all slots free, no result pending, registers at defaults.
module periodic_timer_bank_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [ptb_pkg::OP_W-1:0]        operation,
  input  logic [ptb_pkg::FREQ_W-1:0]      frequency,
  input  logic [ptb_pkg::IDX_W-1:0]       slot_index,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [ptb_pkg::MASK_W-1:0]      fired_mask,
  output logic [ptb_pkg::IDX_W-1:0]       assigned_slot,
  output logic [ptb_pkg::STATUS_W-1:0]    status,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ptb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ptb_pkg::FREQ_W-1:0]      cfg_data
);
  import ptb_pkg::*;

  ptb_cmd_t  cmd;
  ptb_stat_t stat;

  // Config writes are always accepted
  assign cfg_ready = 1'b1;

  ptb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ptb_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .operation     (operation),
    .frequency     (frequency),
    .slot_index    (slot_index),
    .cfg_write     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .fired_mask    (fired_mask),
    .assigned_slot (assigned_slot),
    .status        (status)
  );

endmodule
